/* hw/rtl/amw_pkg.sv */
// Shared types, constants and register codes of the affine mask warp block.
`default_nettype none

package amw_pkg;

    // Default parameter values.
    localparam int DST_WIDTH_DEF      = 608;
    localparam int DST_HEIGHT_DEF     = 684;
    localparam int SRC_MAX_WIDTH_DEF  = 1024;
    localparam int SRC_MAX_HEIGHT_DEF = 1024;
    localparam int FRAC_BITS_DEF      = 16;

    // Field widths.
    localparam int POS_W      = 10;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 32;
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // A coefficient times a zero-extended position, and the sum of two such plus an offset.
    localparam int PROD_W = COEF_W + POS_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    // Register reset values.
    localparam logic signed [COEF_W-1:0] COEF_ONE_RST  = 32'sd65536;
    localparam logic signed [COEF_W-1:0] COEF_ZERO_RST = 32'sd0;
    localparam logic [SIZE_W-1:0]        SIZE_RST      = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_SX   = 3'd0,
        REG_COEF_RY   = 3'd1,
        REG_COEF_TX   = 3'd2,
        REG_COEF_RX   = 3'd3,
        REG_COEF_SY   = 3'd4,
        REG_COEF_TY   = 3'd5,
        REG_SRC_WIDTH = 3'd6,
        REG_SRC_HEIGHT = 3'd7
    } reg_index_t;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [PIX_W-1:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] out_col;
        logic [POS_W-1:0] out_row;
        logic             mask_bit;
    } out_item_t;

endpackage

`default_nettype wire

/* hw/rtl/affine_mask_warp.sv */
// Top level of the affine mask warp: coefficient registers, warp pipeline and banked mask store.
`default_nettype none

// Write transactions store one source mask bit; query transactions map an output pixel
// through the affine transform and return one result with the sampled bit. The block takes
// one transaction every cycle while the result side is not stalled. A query result passes
// through five register stages: multiply, add, range check and address, mask read and
// result register. The mask store is split into four banks by column and row parity, so the
// four neighbours of a position are read in the same cycle, one read per bank. A stall on
// the result side holds the whole pipeline.
// The mask store is not cleared at reset: a pixel must be written before a query reads it.
// Configuration registers take effect at once and are to be written while no transaction is
// in flight.
module affine_mask_warp
    import amw_pkg::*;
#(
    parameter int DST_WIDTH      = DST_WIDTH_DEF,
    parameter int DST_HEIGHT     = DST_HEIGHT_DEF,
    parameter int SRC_MAX_WIDTH  = SRC_MAX_WIDTH_DEF,
    parameter int SRC_MAX_HEIGHT = SRC_MAX_HEIGHT_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    item_valid,
    output logic                   item_ready,
    input  in_item_t               item,
    output logic                   result_valid,
    input  wire                    result_ready,
    output out_item_t              result,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_data
);

    localparam int XW = $clog2(SRC_MAX_WIDTH);
    localparam int YW = $clog2(SRC_MAX_HEIGHT);
    localparam int EW_A = (XW > YW) ? XW + 1 : YW + 1;
    localparam int EW = (EW_A > SIZE_W) ? EW_A : SIZE_W;
    localparam int XI_W = SUM_W - 1 - FRAC_BITS;
    localparam int AB = XW + YW - 2;
    localparam int BANK_DEPTH = 1 << AB;

    // Configuration registers.
    logic signed [COEF_W-1:0] coef_sx_reg, coef_ry_reg, coef_tx_reg;
    logic signed [COEF_W-1:0] coef_rx_reg, coef_sy_reg, coef_ty_reg;
    logic [SIZE_W-1:0]        src_width_reg, src_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_sx_reg    <= COEF_ONE_RST;
            coef_ry_reg    <= COEF_ZERO_RST;
            coef_tx_reg    <= COEF_ZERO_RST;
            coef_rx_reg    <= COEF_ZERO_RST;
            coef_sy_reg    <= COEF_ONE_RST;
            coef_ty_reg    <= COEF_ZERO_RST;
            src_width_reg  <= SIZE_RST;
            src_height_reg <= SIZE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_COEF_SX:    coef_sx_reg    <= $signed(cfg_data);
                REG_COEF_RY:    coef_ry_reg    <= $signed(cfg_data);
                REG_COEF_TX:    coef_tx_reg    <= $signed(cfg_data);
                REG_COEF_RX:    coef_rx_reg    <= $signed(cfg_data);
                REG_COEF_SY:    coef_sy_reg    <= $signed(cfg_data);
                REG_COEF_TY:    coef_ty_reg    <= $signed(cfg_data);
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together whenever the result register can move.
    logic adv;
    logic result_valid_reg;
    out_item_t result_reg;

    assign adv          = !result_valid_reg || result_ready;
    assign item_ready   = adv;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- Stage 1: products ----------------
    logic signed [PROD_W-1:0] p_sx_next, p_ry_next, p_rx_next, p_sy_next;
    logic                     in_panel_next;

    assign p_sx_next = coef_sx_reg * $signed({1'b0, item.pos_x});
    assign p_ry_next = coef_ry_reg * $signed({1'b0, item.pos_y});
    assign p_rx_next = coef_rx_reg * $signed({1'b0, item.pos_x});
    assign p_sy_next = coef_sy_reg * $signed({1'b0, item.pos_y});
    assign in_panel_next = ({1'b0, item.pos_x} < (POS_W + 1)'(DST_WIDTH))
                        && ({1'b0, item.pos_y} < (POS_W + 1)'(DST_HEIGHT));

    logic                     s1_valid_reg;
    logic                     s1_query_reg;
    logic [POS_W-1:0]         s1_col_reg, s1_row_reg;
    logic                     s1_in_panel_reg, s1_set_reg;
    logic signed [PROD_W-1:0] s1_p_sx_reg, s1_p_ry_reg, s1_p_rx_reg, s1_p_sy_reg;

    // ---------------- Stage 2: sums ----------------
    logic signed [SUM_W-1:0] x_next, y_next;

    assign x_next = SUM_W'(s1_p_sx_reg) + SUM_W'(s1_p_ry_reg) + SUM_W'(coef_tx_reg);
    assign y_next = SUM_W'(s1_p_rx_reg) + SUM_W'(s1_p_sy_reg) + SUM_W'(coef_ty_reg);

    logic                    s2_valid_reg;
    logic                    s2_query_reg;
    logic [POS_W-1:0]        s2_col_reg, s2_row_reg;
    logic                    s2_in_panel_reg, s2_set_reg;
    logic signed [SUM_W-1:0] s2_x_reg, s2_y_reg;

    // ---------------- Stage 3: range check and neighbour selection ----------------
    logic [EW-1:0]     w_eff, h_eff;
    logic [XI_W-1:0]   x_int, y_int;
    logic [XW-1:0]     qx0;
    logic [YW-1:0]     qy0;
    logic [EW-1:0]     qx0_inc, qy0_inc;
    logic              hit_next, use_x1_next, use_y1_next, wen_next;
    logic [XW-1:0]     x0_next;
    logic [YW-1:0]     y0_next;

    always_comb
    begin
        w_eff = (EW'(src_width_reg) > EW'(SRC_MAX_WIDTH)) ? EW'(SRC_MAX_WIDTH)
                                                          : EW'(src_width_reg);
        h_eff = (EW'(src_height_reg) > EW'(SRC_MAX_HEIGHT)) ? EW'(SRC_MAX_HEIGHT)
                                                            : EW'(src_height_reg);
        x_int = s2_x_reg[SUM_W-2:FRAC_BITS];
        y_int = s2_y_reg[SUM_W-2:FRAC_BITS];
        qx0   = s2_x_reg[FRAC_BITS+XW-1:FRAC_BITS];
        qy0   = s2_y_reg[FRAC_BITS+YW-1:FRAC_BITS];
        qx0_inc = EW'(qx0) + EW'(1);
        qy0_inc = EW'(qy0) + EW'(1);

        // A zero size gives an empty source, since no integer part is below zero.
        hit_next = s2_in_panel_reg && !s2_x_reg[SUM_W-1] && !s2_y_reg[SUM_W-1]
                && (x_int < XI_W'(w_eff)) && (y_int < XI_W'(h_eff));
        // A clamped neighbour repeats the floor pixel and adds nothing.
        use_x1_next = (|s2_x_reg[FRAC_BITS-1:0]) && (qx0_inc < w_eff);
        use_y1_next = (|s2_y_reg[FRAC_BITS-1:0]) && (qy0_inc < h_eff);
        wen_next = s2_valid_reg && !s2_query_reg
                && (EW'(s2_col_reg) < EW'(SRC_MAX_WIDTH))
                && (EW'(s2_row_reg) < EW'(SRC_MAX_HEIGHT));

        if (s2_query_reg)
        begin
            x0_next = qx0;
            y0_next = qy0;
        end
        else
        begin
            x0_next = XW'(s2_col_reg);
            y0_next = YW'(s2_row_reg);
        end
    end

    logic              s3_valid_reg;
    logic              s3_query_reg;
    logic [POS_W-1:0]  s3_col_reg, s3_row_reg;
    logic              s3_hit_reg, s3_use_x1_reg, s3_use_y1_reg, s3_wen_reg, s3_set_reg;
    logic [XW-1:0]     s3_x0_reg;
    logic [YW-1:0]     s3_y0_reg;

    // ---------------- Stage 4: banked mask store ----------------
    // Bank index is {row parity, column parity}. The even and odd column (row) of a
    // neighbour pair always fall into different banks.
    logic [XW:0]    x0_inc_a;
    logic [YW:0]    y0_inc_a;
    logic [XW-2:0]  col_even, col_odd;
    logic [YW-2:0]  row_even, row_odd;
    logic [AB-1:0]  bank_addr [4];
    logic [3:0]     bank_we;
    wire  [3:0]     bank_q;

    always_comb
    begin
        x0_inc_a = {1'b0, s3_x0_reg} + (XW + 1)'(1);
        y0_inc_a = {1'b0, s3_y0_reg} + (YW + 1)'(1);
        col_even = x0_inc_a[XW-1:1];
        col_odd  = s3_x0_reg[XW-1:1];
        row_even = y0_inc_a[YW-1:1];
        row_odd  = s3_y0_reg[YW-1:1];
        for (int b = 0; b < 4; b++)
        begin
            bank_addr[b] = {(b[1] ? row_odd : row_even), (b[0] ? col_odd : col_even)};
            bank_we[b]   = s3_valid_reg && s3_wen_reg
                        && (s3_y0_reg[0] == b[1]) && (s3_x0_reg[0] == b[0]);
        end
    end

    for (genvar gb = 0; gb < 4; gb++)
    begin : g_bank
        logic mem [BANK_DEPTH];
        logic rd_reg;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (bank_we[gb])
                begin
                    mem[bank_addr[gb]] <= s3_set_reg;
                end
                rd_reg <= mem[bank_addr[gb]];
            end
        end

        assign bank_q[gb] = rd_reg;
    end

    logic              s4_valid_reg;
    logic              s4_query_reg;
    logic [POS_W-1:0]  s4_col_reg, s4_row_reg;
    logic              s4_hit_reg, s4_use_x1_reg, s4_use_y1_reg;
    logic              s4_xp_reg, s4_yp_reg;

    // ---------------- Stage 5: combine neighbours ----------------
    logic b00, b10, b01, b11, bit_next;

    always_comb
    begin
        b00 = bank_q[{s4_yp_reg, s4_xp_reg}];
        b10 = bank_q[{s4_yp_reg, !s4_xp_reg}];
        b01 = bank_q[{!s4_yp_reg, s4_xp_reg}];
        b11 = bank_q[{!s4_yp_reg, !s4_xp_reg}];
        bit_next = s4_hit_reg && (b00 || (s4_use_x1_reg && b10) || (s4_use_y1_reg && b01)
                                  || (s4_use_x1_reg && s4_use_y1_reg && b11));
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg     <= item_valid;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            result_valid_reg <= s4_valid_reg && s4_query_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_query_reg    <= (item.func == FUNC_QUERY);
            s1_col_reg      <= item.pos_x;
            s1_row_reg      <= item.pos_y;
            s1_in_panel_reg <= in_panel_next;
            s1_set_reg      <= |item.pixel_value;
            s1_p_sx_reg     <= p_sx_next;
            s1_p_ry_reg     <= p_ry_next;
            s1_p_rx_reg     <= p_rx_next;
            s1_p_sy_reg     <= p_sy_next;

            s2_query_reg    <= s1_query_reg;
            s2_col_reg      <= s1_col_reg;
            s2_row_reg      <= s1_row_reg;
            s2_in_panel_reg <= s1_in_panel_reg;
            s2_set_reg      <= s1_set_reg;
            s2_x_reg        <= x_next;
            s2_y_reg        <= y_next;

            s3_query_reg    <= s2_query_reg;
            s3_col_reg      <= s2_col_reg;
            s3_row_reg      <= s2_row_reg;
            s3_hit_reg      <= hit_next;
            s3_use_x1_reg   <= use_x1_next;
            s3_use_y1_reg   <= use_y1_next;
            s3_wen_reg      <= wen_next;
            s3_set_reg      <= s2_set_reg;
            s3_x0_reg       <= x0_next;
            s3_y0_reg       <= y0_next;

            s4_query_reg    <= s3_query_reg;
            s4_col_reg      <= s3_col_reg;
            s4_row_reg      <= s3_row_reg;
            s4_hit_reg      <= s3_hit_reg;
            s4_use_x1_reg   <= s3_use_x1_reg;
            s4_use_y1_reg   <= s3_use_y1_reg;
            s4_xp_reg       <= s3_x0_reg[0];
            s4_yp_reg       <= s3_y0_reg[0];

            result_reg.out_col  <= s4_col_reg;
            result_reg.out_row  <= s4_row_reg;
            result_reg.mask_bit <= bit_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/amw_checker.sv */
// Port-level checker for the affine mask warp, with its bind to the top level.
`default_nettype none

module amw_checker
    import amw_pkg::*;
#(
    parameter int DST_WIDTH  = DST_WIDTH_DEF,
    parameter int DST_HEIGHT = DST_HEIGHT_DEF
) (
    input wire       clk,
    input wire       rst_n,
    input wire       item_ready,
    input wire       result_valid,
    input wire       result_ready,
    input out_item_t result
);

    // A result that is not taken stays, unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // A stalled result holds back new transactions; an empty output never does.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !item_ready)
        else $error("input accepted while the result side is stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input blocked with no pending result");

    // Pixels beyond the panel are always off.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (({1'b0, result.out_col} >= (POS_W + 1)'(DST_WIDTH))
                      || ({1'b0, result.out_row} >= (POS_W + 1)'(DST_HEIGHT)))
        |-> !result.mask_bit)
        else $error("mask bit set beyond the panel");

endmodule

bind affine_mask_warp amw_checker #(
    .DST_WIDTH  (DST_WIDTH),
    .DST_HEIGHT (DST_HEIGHT)
) u_amw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
